// ----- rtl/core/bvp_pkg.sv -----
// Shared types, constants and saturation helpers for the tridiagonal sweep solver.
// Used by bvp_div and the solver core; depends on nothing else.
`default_nettype none
package bvp_pkg;

  localparam int MAX_INTERVALS = 63;
  localparam int MIN_INTERVALS = 4;

  // Configuration register indexes.
  localparam logic [2:0] REG_LEFT_END    = 3'd0;
  localparam logic [2:0] REG_RIGHT_END   = 3'd1;
  localparam logic [2:0] REG_LEFT_VALUE  = 3'd2;
  localparam logic [2:0] REG_RIGHT_VALUE = 3'd3;
  localparam logic [2:0] REG_P_GAIN      = 3'd4;
  localparam logic [2:0] REG_Q_GAIN      = 3'd5;
  localparam logic [2:0] REG_COUNT       = 3'd6;

  // Reset values in Q16.16.
  localparam logic signed [31:0] RST_LEFT_END    = -32'sd131072;
  localparam logic signed [31:0] RST_RIGHT_END   = -32'sd65536;
  localparam logic signed [31:0] RST_LEFT_VALUE  = 32'sd3014656;
  localparam logic signed [31:0] RST_RIGHT_VALUE = 32'sd1638400;
  localparam logic signed [31:0] RST_P_GAIN      = -32'sd262144;
  localparam logic signed [31:0] RST_Q_GAIN      = -32'sd196608;
  localparam logic [5:0]         RST_COUNT       = 6'd20;

  // Saturation bounds, held in the wide working width.
  localparam logic signed [65:0] WMAX = 66'sd2147483647;
  localparam logic signed [65:0] WMIN = -66'sd2147483648;
  localparam logic signed [31:0] QMAX = 32'sh7fffffff;
  localparam logic signed [31:0] QMIN = 32'sh80000000;

  // Constant term of the right side: 6.0 in Q16.16.
  localparam logic signed [65:0] SIX_Q = 66'sd393216;

  // Divider result handed back to the sequencer.
  typedef struct packed {
    logic               done;
    logic signed [48:0] quot;
  } div_res_t;

  function automatic logic signed [65:0] ext(input logic signed [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat_v(input logic signed [65:0] v);
    if (v > WMAX) return QMAX;
    else if (v < WMIN) return QMIN;
    else return v[31:0];
  endfunction

  function automatic logic sat_o(input logic signed [65:0] v);
    return (v > WMAX) || (v < WMIN);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/bvp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the sweep and solution stores; no package dependency.
`default_nettype none
module bvp_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/bvp_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on bvp_pkg for the result struct.
`default_nettype none
module bvp_div
  import bvp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [48:0] dividend,
  input  wire logic signed [32:0] divisor,
  output div_res_t                res
);

  logic [47:0] dq;
  logic [33:0] rem;
  logic [32:0] vmag;
  logic        neg;
  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [48:0] dmag_w;
  logic [32:0] vmag_w;
  logic [33:0] rem_sh;
  logic        fits;
  logic [48:0] quot_w;

  // Magnitudes of the operands and the next partial remainder.
  always_comb begin
    dmag_w = dividend[48] ? 49'(-dividend) : dividend;
    vmag_w = divisor[32] ? 33'(-divisor) : divisor;
    rem_sh = {rem[32:0], dq[47]};
    fits   = rem_sh >= {1'b0, vmag};
  end

  // Iteration control; the quotient bits shift into the dividend register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dq   <= dmag_w[47:0];
        vmag <= vmag_w;
        rem  <= '0;
        neg  <= dividend[48] ^ divisor[32];
      end else if (busy) begin
        rem <= fits ? 34'(rem_sh - {1'b0, vmag}) : rem_sh;
        dq  <= {dq[46:0], fits};
        cnt <= 6'(cnt + 6'd1);
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Signed quotient and completion pulse.
  assign quot_w = neg ? 49'(-{1'b0, dq}) : {1'b0, dq};
  assign res    = {done, quot_w};

endmodule
`default_nettype wire

// ----- rtl/core/bvp_tridiagonal_sweep_solver_core.sv -----
// Solver core: configuration registers, sweep sequencer, multiplier and stores.
// Depends on bvp_pkg, bvp_div and bvp_ram.
//
// Usage: configuration registers are written through cfg_we/cfg_index/cfg_data
// while the core is idle. An input transfer on s_* with start_req (bit 0 of
// s_tdata) set launches a solve; a transfer with it clear is taken and dropped.
// s_tready is high only while idle, so one solve runs at a time.
// The solve emits n+1 point transfers on m_*, index 0 first, m_tlast on index n.
// Per solve, with n the clamped interval count: setup runs two divisions, for h
// and 1/h; the forward sweep runs n-1 rows, each with two divisions on the
// shared divider; then come the back substitution rows and the points out.
// The divider is the limit: it yields one quotient bit a cycle.
// Each point waits in the output register until taken; a stalled receiver
// holds the sequencer, nothing is lost. The stores hold no meaningful data
// after reset and need no clearing: every entry is written before it is read.
// Synchronous reset returns the sequencer to idle and the registers to their
// reset values.
`default_nettype none
module bvp_tridiagonal_sweep_solver_core
  import bvp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Start request: [0] start_req.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,
  // Point: [5:0] point_index, [37:6] grid_x, [69:38] solution_y, zero fill.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,
  // Flags: [0] singular or saturated (any overflow during the solve).
  output logic             m_tuser,
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE, ST_HDIV, ST_RGO, ST_RDIV, ST_R2M, ST_R2, ST_PR, ST_COEF, ST_COEF2,
    ST_K0, ST_K1, ST_K2, ST_K3, ST_K4, ST_K5, ST_K6, ST_K7, ST_K8, ST_K9,
    ST_K10, ST_K11, ST_K12, ST_K13, ST_UGO, ST_UDIV, ST_VGO, ST_VDIV,
    ST_B0, ST_B1, ST_B2, ST_B3, ST_B4, ST_B5, ST_O0, ST_O1, ST_O2
  } state_t;

  state_t state;

  // Configuration registers.
  logic signed [31:0] left_end, right_end, left_value, right_value;
  logic signed [31:0] p_gain, q_gain;
  logic [5:0]         interval_count;

  // Solve registers.
  logic [5:0]         n_eff, k, idx;
  logic               ovf;
  logic signed [31:0] h, r, r2, pr, ca, cb, cc, negb, cc2;
  logic signed [31:0] x, x2, t, d, den, uprev, vprev, yprev;
  logic signed [63:0] prod;

  // Multiplier operands, divider port and store ports.
  logic signed [31:0] mul_a, mul_b;
  logic               div_start;
  logic signed [48:0] div_num;
  logic signed [32:0] div_den;
  div_res_t           div_res;
  logic [5:0]         uv_raddr, y_raddr, y_waddr;
  logic               u_we, v_we, y_we;
  logic [31:0]        u_rd, v_rd, y_rd, y_wdata;

  // Working values.
  logic [5:0]         n_cl, kp1;
  logic signed [65:0] mq_w, prod_w, qt_w;
  logic signed [31:0] mq, qsat, s3, s6, s2, tsum, t2;
  logic signed [32:0] span;
  logic               start_ok;

  assign s_tready = (state == ST_IDLE);
  assign start_ok = s_tvalid && s_tready && s_tdata[0];
  assign n_cl     = (interval_count < 6'(MIN_INTERVALS)) ? 6'(MIN_INTERVALS)
                                                         : interval_count;
  assign kp1      = 6'(k + 6'd1);
  assign span     = 33'(ext(right_end) - ext(left_end));

  // Fixed-point truncation and saturation of the registered product, the quotient and derived terms.
  always_comb begin
    prod_w = $signed({{2{prod[63]}}, prod});
    mq_w   = $signed({{2{prod[63]}}, prod}) >>> 16;
    mq     = sat_v(mq_w);
    qt_w   = {{17{div_res.quot[48]}}, div_res.quot};
    qsat   = sat_v(qt_w);
    s3     = sat_v(ext(mq) * 3);
    s6     = sat_v(ext(x2) * 6);
    tsum   = sat_v(ext(s3) + ext(s6));
    s2     = sat_v(ext(x) * 2);
    t2     = sat_v(ext(t) + ext(s2));
  end

  // Multiplier operand selection per sequencer step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_K0:  begin mul_a = {26'd0, kp1}; mul_b = h; end
      ST_O0:  begin mul_a = {26'd0, idx}; mul_b = h; end
      ST_R2M: begin mul_a = r;  mul_b = r; end
      ST_R2:  begin mul_a = p_gain; mul_b = r; end
      ST_K2:  begin mul_a = x;  mul_b = x; end
      ST_K4:  begin mul_a = x2; mul_b = x; end
      ST_K7:  begin mul_a = ca; mul_b = left_value; end
      ST_K9:  begin mul_a = cb; mul_b = right_value; end
      ST_K11: begin mul_a = ca; mul_b = vprev; end
      ST_K12: begin mul_a = ca; mul_b = uprev; end
      ST_B4:  begin mul_a = v_rd; mul_b = yprev; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Divider launch and operands.
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      ST_IDLE: begin
        div_start = start_ok;
        div_num   = {{16{span[32]}}, span};
        div_den   = {27'd0, n_cl};
      end
      ST_RGO: begin
        div_start = 1'b1;
        div_num   = 49'sh1_0000_0000;
        div_den   = {h[31], h};
      end
      ST_UGO: begin
        div_start = 1'b1;
        div_num   = {d[31], d, 16'd0};
        div_den   = {den[31], den};
      end
      ST_VGO: begin
        div_start = 1'b1;
        div_num   = {negb[31], negb, 16'd0};
        div_den   = {den[31], den};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Store addressing and write data.
  always_comb begin
    uv_raddr = 6'(k - 6'd1);
    if (state == ST_B0) uv_raddr = 6'(n_eff - 6'd2);
    else if (state == ST_B3) uv_raddr = 6'(idx - 6'd1);
    u_we    = (state == ST_UDIV) && div_res.done;
    v_we    = (state == ST_VDIV) && div_res.done;
    y_raddr = idx;
    y_we    = 1'b0;
    y_waddr = idx;
    y_wdata = yprev;
    case (state)
      ST_B0: begin y_we = 1'b1; y_waddr = 6'd0; y_wdata = left_value; end
      ST_B1: begin y_we = 1'b1; y_waddr = n_eff; y_wdata = right_value; end
      ST_B2: begin y_we = 1'b1; y_waddr = 6'(n_eff - 6'd1); y_wdata = yprev; end
      ST_B5: begin y_we = 1'b1; y_waddr = idx; y_wdata = sat_v(ext(uprev) + ext(mq)); end
      default: y_we = 1'b0;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_end       <= RST_LEFT_END;
      right_end      <= RST_RIGHT_END;
      left_value     <= RST_LEFT_VALUE;
      right_value    <= RST_RIGHT_VALUE;
      p_gain         <= RST_P_GAIN;
      q_gain         <= RST_Q_GAIN;
      interval_count <= RST_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT_END:    left_end       <= cfg_data;
        REG_RIGHT_END:   right_end      <= cfg_data;
        REG_LEFT_VALUE:  left_value     <= cfg_data;
        REG_RIGHT_VALUE: right_value    <= cfg_data;
        REG_P_GAIN:      p_gain         <= cfg_data;
        REG_Q_GAIN:      q_gain         <= cfg_data;
        REG_COUNT:       interval_count <= cfg_data[5:0];
        default:         ;
      endcase
    end
  end

  // Multiplier output register.
  always_ff @(posedge clk) begin
    prod <= 64'(mul_a * mul_b);
  end

  // Sequencer: setup, forward sweep, back substitution and point output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      k        <= '0;
      idx      <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start_ok) begin
            ovf   <= 1'b0;
            n_eff <= n_cl;
            state <= ST_HDIV;
          end
        end
        ST_HDIV: begin
          if (div_res.done) begin
            h     <= qsat;
            ovf   <= ovf | sat_o(qt_w);
            state <= ST_RGO;
          end
        end
        ST_RGO: state <= ST_RDIV;
        ST_RDIV: begin
          if (div_res.done) begin
            r     <= (h == 32'sd0) ? 32'sd0 : qsat;
            ovf   <= ovf | (h == 32'sd0) | ((h != 32'sd0) & sat_o(qt_w));
            state <= ST_R2M;
          end
        end
        ST_R2M: state <= ST_R2;
        ST_R2: begin
          r2    <= mq;
          ovf   <= ovf | sat_o(mq_w);
          state <= ST_PR;
        end
        ST_PR: begin
          pr    <= mq >>> 1;
          ovf   <= ovf | sat_o(mq_w);
          state <= ST_COEF;
        end
        ST_COEF: begin
          ca    <= sat_v(ext(r2) - ext(pr));
          cb    <= sat_v(ext(r2) + ext(pr));
          cc2   <= sat_v(ext(r2) + ext(r2));
          ovf   <= ovf | sat_o(ext(r2) - ext(pr)) | sat_o(ext(r2) + ext(pr))
                       | sat_o(ext(r2) + ext(r2));
          state <= ST_COEF2;
        end
        ST_COEF2: begin
          cc    <= sat_v(ext(q_gain) - ext(cc2));
          negb  <= sat_v(-ext(cb));
          ovf   <= ovf | sat_o(ext(q_gain) - ext(cc2)) | sat_o(-ext(cb));
          k     <= '0;
          state <= ST_K0;
        end
        ST_K0: state <= ST_K1;
        ST_K1: begin
          x     <= sat_v(ext(left_end) + prod_w);
          ovf   <= ovf | sat_o(ext(left_end) + prod_w);
          uprev <= u_rd;
          vprev <= v_rd;
          state <= ST_K2;
        end
        ST_K2: state <= ST_K3;
        ST_K3: begin
          x2    <= mq;
          ovf   <= ovf | sat_o(mq_w);
          state <= ST_K4;
        end
        ST_K4: state <= ST_K5;
        ST_K5: begin
          t     <= tsum;
          ovf   <= ovf | sat_o(mq_w) | sat_o(ext(mq) * 3) | sat_o(ext(x2) * 6)
                       | sat_o(ext(s3) + ext(s6));
          state <= ST_K6;
        end
        ST_K6: begin
          d     <= sat_v(ext(t2) - SIX_Q);
          ovf   <= ovf | sat_o(ext(x) * 2) | sat_o(ext(t) + ext(s2))
                       | sat_o(ext(t2) - SIX_Q);
          state <= ST_K7;
        end
        ST_K7: state <= (k == 6'd0) ? ST_K8 : ST_K9;
        ST_K8: begin
          d     <= sat_v(ext(d) - ext(mq));
          ovf   <= ovf | sat_o(mq_w) | sat_o(ext(d) - ext(mq));
          state <= ST_K9;
        end
        ST_K9: state <= (k == 6'(n_eff - 6'd2)) ? ST_K10 : ST_K11;
        ST_K10: begin
          d     <= sat_v(ext(d) - ext(mq));
          ovf   <= ovf | sat_o(mq_w) | sat_o(ext(d) - ext(mq));
          state <= ST_K11;
        end
        ST_K11: begin
          if (k == 6'd0) begin
            den   <= cc;
            state <= ST_UGO;
          end else begin
            state <= ST_K12;
          end
        end
        ST_K12: begin
          den   <= sat_v(ext(mq) + ext(cc));
          ovf   <= ovf | sat_o(mq_w) | sat_o(ext(mq) + ext(cc));
          state <= ST_K13;
        end
        ST_K13: begin
          d     <= sat_v(ext(d) - ext(mq));
          ovf   <= ovf | sat_o(mq_w) | sat_o(ext(d) - ext(mq));
          state <= ST_UGO;
        end
        ST_UGO: state <= ST_UDIV;
        ST_UDIV: begin
          if (div_res.done) begin
            ovf   <= ovf | (den == 32'sd0) | ((den != 32'sd0) & sat_o(qt_w));
            state <= ST_VGO;
          end
        end
        ST_VGO: state <= ST_VDIV;
        ST_VDIV: begin
          if (div_res.done) begin
            ovf <= ovf | (den == 32'sd0) | ((den != 32'sd0) & sat_o(qt_w));
            if (k == 6'(n_eff - 6'd2)) begin
              state <= ST_B0;
            end else begin
              k     <= kp1;
              state <= ST_K0;
            end
          end
        end
        ST_B0: state <= ST_B1;
        ST_B1: begin
          yprev <= u_rd;
          state <= ST_B2;
        end
        ST_B2: begin
          idx   <= 6'(n_eff - 6'd2);
          state <= ST_B3;
        end
        ST_B3: state <= ST_B4;
        ST_B4: begin
          uprev <= u_rd;
          state <= ST_B5;
        end
        ST_B5: begin
          yprev <= sat_v(ext(uprev) + ext(mq));
          ovf   <= ovf | sat_o(mq_w) | sat_o(ext(uprev) + ext(mq));
          if (idx == 6'd1) begin
            idx   <= '0;
            state <= ST_O0;
          end else begin
            idx   <= 6'(idx - 6'd1);
            state <= ST_B3;
          end
        end
        ST_O0: state <= ST_O1;
        ST_O1: begin
          m_tdata[5:0]   <= idx;
          m_tdata[37:6]  <= (idx == 6'd0) ? left_end :
                            (idx == n_eff) ? right_end :
                            sat_v(ext(left_end) + prod_w);
          m_tdata[69:38] <= y_rd;
          m_tdata[71:70] <= 2'b00;
          m_tuser        <= ovf;
          m_tlast        <= (idx == n_eff);
          m_tvalid       <= 1'b1;
          state          <= ST_O2;
        end
        ST_O2: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (idx == n_eff) begin
              state <= ST_IDLE;
            end else begin
              idx   <= 6'(idx + 6'd1);
              state <= ST_O0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  bvp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .res      (div_res)
  );

  bvp_ram #(.DEPTH(MAX_INTERVALS - 1), .WIDTH(32)) u_sweep_u (
    .clk   (clk),
    .we    (u_we),
    .waddr (k),
    .wdata ((den == 32'sd0) ? 32'd0 : qsat),
    .raddr (uv_raddr),
    .rdata (u_rd)
  );

  bvp_ram #(.DEPTH(MAX_INTERVALS - 1), .WIDTH(32)) u_sweep_v (
    .clk   (clk),
    .we    (v_we),
    .waddr (k),
    .wdata ((den == 32'sd0) ? 32'd0 : qsat),
    .raddr (uv_raddr),
    .rdata (v_rd)
  );

  bvp_ram #(.DEPTH(MAX_INTERVALS + 1), .WIDTH(32)) u_solution (
    .clk   (clk),
    .we    (y_we),
    .waddr (y_waddr),
    .wdata (y_wdata),
    .raddr (y_raddr),
    .rdata (y_rd)
  );

`ifndef SYNTHESIS
  // A point is only offered from the output wait state.
  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> state == ST_O2) else $error("point offered outside output state");

  // A new start is never taken while a point is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("start accepted during output");

  // The last flag marks exactly the final grid index.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[5:0] == n_eff)))
    else $error("last flag on wrong index");

  // Sweep stores are written only when the divider finishes.
  a_sweep_write: assert property (@(posedge clk) disable iff (rst)
    (u_we || v_we) |-> div_res.done) else $error("sweep write without quotient");
`endif

endmodule
`default_nettype wire
